/* src/iss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_pkg
// Shared types and constants for the indexed sequence store.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_READ_ALL  = 3'd6,
    CMD_UNUSED    = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_OOB   = 2'd2,
    STS_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         index;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] element;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } rsp_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t                 op;
    logic [CNT_W-1:0]         pos;
    logic [CNT_W-1:0]         last_pos;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] head;
  } cell_ctl_t;

endpackage

/* src/iss_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_cell
// One storage cell of the chain: holds, takes a neighbor, or loads a value.
// ----------------------------------------------------------------------------
module iss_cell (
  input  logic                             clk,
  input  logic [iss_pkg::CNT_W-1:0]        slot,
  input  iss_pkg::cell_ctl_t               ctl,
  input  logic signed [iss_pkg::DATA_W-1:0] left,
  input  logic signed [iss_pkg::DATA_W-1:0] right,
  output logic signed [iss_pkg::DATA_W-1:0] q
);

  logic signed [iss_pkg::DATA_W-1:0] q_next;

  always_comb begin
    q_next = q;
    case (ctl.op)
      iss_pkg::CELL_INS: begin
        if (slot == ctl.pos) begin
          q_next = ctl.value;
        end else if (slot > ctl.pos) begin
          q_next = left;
        end
      end
      iss_pkg::CELL_DEL: begin
        if (slot >= ctl.pos) begin
          q_next = right;
        end
      end
      iss_pkg::CELL_ROT: begin
        // head wraps around to the tail of the occupied run
        if (slot == ctl.last_pos) begin
          q_next = ctl.head;
        end else if (slot < ctl.last_pos) begin
          q_next = right;
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

/* src/indexed_sequence_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_sequence_store
// Bounded ordered list of signed values held in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. Edit commands
//   (insert front/back/at, delete front/back/at) shift the cell chain at the
//   edge that takes the request and give one result with last set in the
//   cycle after it. Edits run back to back, one per cycle, while busy is low.
//   Read all rotates the chain through its head cell, one element per cycle:
//   results pass through the read state and the result register and come
//   on consecutive cycles, last set on the final one; busy is high while the
//   rotation runs, so a read holds the request side until its final element
//   is rotated. An empty store answers read all with a single empty result.
//   Each result sits on rsp for exactly one cycle, marked by done; the
//   receiver has no way to stall and must take it.
//   Command code 7 is ignored and gives no result.
//   Synchronous reset empties the store and drops any read in progress.
//   Cell contents are not cleared; cells beyond the fill count are never read.
// ----------------------------------------------------------------------------
module indexed_sequence_store (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  iss_pkg::req_t req,
  output logic          done,
  output iss_pkg::rsp_t rsp
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t                        state, state_next;
  logic [iss_pkg::CNT_W-1:0]     fill, fill_next;
  logic [iss_pkg::CNT_W-1:0]     rd_left, rd_left_next;
  logic                          done_next;
  iss_pkg::rsp_t                 rsp_next;
  iss_pkg::cell_ctl_t            ctl;
  logic [iss_pkg::CNT_W-1:0]     ins_pos;
  logic [iss_pkg::CNT_W-1:0]     del_pos;
  logic signed [iss_pkg::DATA_W-1:0] cell_q [iss_pkg::DEPTH];

  assign busy = (state == ST_READ);

  always_comb begin
    case (req.command)
      iss_pkg::CMD_INS_FRONT: ins_pos = '0;
      iss_pkg::CMD_INS_BACK:  ins_pos = fill;
      default:                ins_pos = req.index;
    endcase
    case (req.command)
      iss_pkg::CMD_DEL_FRONT: del_pos = '0;
      iss_pkg::CMD_DEL_BACK:  del_pos = fill - 1'b1;
      default:                del_pos = req.index;
    endcase
  end

  always_comb begin
    state_next       = state;
    fill_next        = fill;
    rd_left_next     = rd_left;
    done_next        = 1'b0;
    rsp_next.status  = iss_pkg::STS_OK;
    rsp_next.element = '0;
    rsp_next.count   = fill;
    rsp_next.last    = 1'b1;
    ctl.op           = iss_pkg::CELL_HOLD;
    ctl.pos          = ins_pos;
    ctl.last_pos     = fill - 1'b1;
    ctl.value        = req.value;
    ctl.head         = cell_q[0];

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          case (req.command) inside
            iss_pkg::CMD_INS_FRONT, iss_pkg::CMD_INS_BACK, iss_pkg::CMD_INS_AT: begin
              done_next = 1'b1;
              if (ins_pos > fill) begin
                rsp_next.status = iss_pkg::STS_OOB;
              end else if (fill == iss_pkg::CNT_W'(iss_pkg::DEPTH)) begin
                rsp_next.status = iss_pkg::STS_FULL;
              end else begin
                ctl.op         = iss_pkg::CELL_INS;
                fill_next      = fill + 1'b1;
                rsp_next.count = fill + 1'b1;
              end
            end
            iss_pkg::CMD_DEL_FRONT, iss_pkg::CMD_DEL_BACK, iss_pkg::CMD_DEL_AT: begin
              done_next = 1'b1;
              ctl.pos   = del_pos;
              if (fill == '0) begin
                rsp_next.status = iss_pkg::STS_EMPTY;
              end else if (del_pos >= fill) begin
                rsp_next.status = iss_pkg::STS_OOB;
              end else begin
                ctl.op         = iss_pkg::CELL_DEL;
                fill_next      = fill - 1'b1;
                rsp_next.count = fill - 1'b1;
              end
            end
            iss_pkg::CMD_READ_ALL: begin
              if (fill == '0) begin
                done_next       = 1'b1;
                rsp_next.status = iss_pkg::STS_EMPTY;
              end else begin
                state_next   = ST_READ;
                rd_left_next = fill;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        // emit the head and rotate it to the tail
        done_next        = 1'b1;
        rsp_next.element = cell_q[0];
        rsp_next.last    = (rd_left == iss_pkg::CNT_W'(1));
        ctl.op           = iss_pkg::CELL_ROT;
        rd_left_next     = rd_left - 1'b1;
        if (rd_left == iss_pkg::CNT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  for (genvar i = 0; i < iss_pkg::DEPTH; i++) begin : g_cell
    logic signed [iss_pkg::DATA_W-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == iss_pkg::DEPTH - 1) begin : g_lastc
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end
    iss_cell u_cell (
      .clk   (clk),
      .slot  (iss_pkg::CNT_W'(i)),
      .ctl   (ctl),
      .left  (left_d),
      .right (right_d),
      .q     (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      fill    <= '0;
      rd_left <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      rd_left <= rd_left_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= iss_pkg::CNT_W'(iss_pkg::DEPTH))
    else $error("fill count above depth");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (fill == $past(fill)) || (fill == $past(fill) + 1'b1) ||
             (fill == $past(fill) - 1'b1))
    else $error("fill count moved by more than one");

  a_read_fill_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> $stable(fill))
    else $error("fill count changed during read all");

  a_read_left: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (rd_left != '0) && (rd_left <= fill))
    else $error("read counter out of range");

  a_edit_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.command != iss_pkg::CMD_READ_ALL) &&
     (req.command != iss_pkg::CMD_UNUSED)) |=> done && rsp.last)
    else $error("edit request gave no single result");
`endif

endmodule

/* verif/indexed_sequence_store_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_sequence_store_tb
// Self-checking bench for the indexed sequence store. A directed table walks
// the empty, boundary and full cases, then random command streams push the
// list between empty and full. Every accepted request updates a queue-based
// copy of the list, and each result strobe is checked against the oldest
// owed result.
// ----------------------------------------------------------------------------
module indexed_sequence_store_tb;

  localparam int RANDOM_ITEMS = 220;
  localparam int PLAN_LEN = 25;

  typedef struct {
    logic [2:0]                        command;
    logic signed [iss_pkg::DATA_W-1:0] value;
    logic [iss_pkg::CNT_W-1:0]         index;
    int                                reps;
    bit                                typed;
    iss_pkg::status_t                  status;
    int                                count;
  } plan_row_t;

  // typed rows carry the single result that can be read off directly
  plan_row_t plan [PLAN_LEN] = '{
    '{iss_pkg::CMD_READ_ALL,  32'sd0,         5'd0,  1,  1'b1, iss_pkg::STS_EMPTY, 0},
    '{iss_pkg::CMD_DEL_FRONT, 32'sd0,         5'd0,  1,  1'b1, iss_pkg::STS_EMPTY, 0},
    '{iss_pkg::CMD_DEL_BACK,  32'sd0,         5'd0,  1,  1'b1, iss_pkg::STS_EMPTY, 0},
    '{iss_pkg::CMD_DEL_AT,    32'sd0,         5'd31, 1,  1'b1, iss_pkg::STS_EMPTY, 0},
    '{iss_pkg::CMD_INS_AT,    32'sd5,         5'd1,  1,  1'b1, iss_pkg::STS_OOB,   0},
    '{iss_pkg::CMD_INS_FRONT, 32'sh7FFF_FFFF, 5'd0,  1,  1'b1, iss_pkg::STS_OK,    1},
    '{iss_pkg::CMD_INS_BACK,  32'sh8000_0000, 5'd0,  1,  1'b1, iss_pkg::STS_OK,    2},
    '{iss_pkg::CMD_INS_AT,    32'sd0,         5'd1,  1,  1'b1, iss_pkg::STS_OK,    3},
    '{iss_pkg::CMD_INS_AT,    32'sd7,         5'd4,  1,  1'b1, iss_pkg::STS_OOB,   3},
    '{iss_pkg::CMD_DEL_AT,    32'sd0,         5'd3,  1,  1'b1, iss_pkg::STS_OOB,   3},
    '{iss_pkg::CMD_UNUSED,    -32'sd1,        5'd31, 1,  1'b0, iss_pkg::STS_OK,    0},
    '{iss_pkg::CMD_READ_ALL,  32'sd0,         5'd0,  1,  1'b0, iss_pkg::STS_OK,    0},
    '{iss_pkg::CMD_INS_AT,    -32'sd1,        5'd3,  1,  1'b1, iss_pkg::STS_OK,    4},
    '{iss_pkg::CMD_INS_BACK,  32'sh5555_5550, 5'd0,  12, 1'b0, iss_pkg::STS_OK,    0},
    '{iss_pkg::CMD_INS_FRONT, 32'sh1234_5678, 5'd0,  1,  1'b1, iss_pkg::STS_FULL,  16},
    '{iss_pkg::CMD_INS_AT,    32'sd1,         5'd17, 1,  1'b1, iss_pkg::STS_OOB,   16},
    '{iss_pkg::CMD_INS_AT,    32'sd1,         5'd16, 1,  1'b1, iss_pkg::STS_FULL,  16},
    '{iss_pkg::CMD_INS_BACK,  32'sd1,         5'd0,  1,  1'b1, iss_pkg::STS_FULL,  16},
    '{iss_pkg::CMD_READ_ALL,  32'sd0,         5'd0,  1,  1'b0, iss_pkg::STS_OK,    0},
    '{iss_pkg::CMD_DEL_AT,    32'sd0,         5'd15, 1,  1'b1, iss_pkg::STS_OK,    15},
    '{iss_pkg::CMD_DEL_AT,    32'sd0,         5'd16, 1,  1'b1, iss_pkg::STS_OOB,   15},
    '{iss_pkg::CMD_DEL_FRONT, 32'sd0,         5'd0,  1,  1'b1, iss_pkg::STS_OK,    14},
    '{iss_pkg::CMD_DEL_BACK,  32'sd0,         5'd0,  1,  1'b1, iss_pkg::STS_OK,    13},
    '{iss_pkg::CMD_DEL_AT,    32'sd0,         5'd0,  13, 1'b0, iss_pkg::STS_OK,    0},
    '{iss_pkg::CMD_READ_ALL,  32'sd0,         5'd0,  1,  1'b1, iss_pkg::STS_EMPTY, 0}
  };

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           start = 1'b0;
  iss_pkg::req_t  req = '0;
  logic           busy;
  logic           done;
  iss_pkg::rsp_t  rsp;

  logic signed [iss_pkg::DATA_W-1:0] held[$];
  iss_pkg::rsp_t                     owed_results[$];
  int                                mismatches = 0;
  bit                                growing = 1'b1;

  indexed_sequence_store dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t ns mismatch: %s", $time, what);
  endtask

  function automatic iss_pkg::rsp_t make_result(
    input iss_pkg::status_t                  st,
    input logic signed [iss_pkg::DATA_W-1:0] el,
    input int                                cnt,
    input bit                                lst
  );
    iss_pkg::rsp_t r;
    r.status  = st;
    r.element = el;
    r.count   = cnt[iss_pkg::CNT_W-1:0];
    r.last    = lst;
    return r;
  endfunction

  // bounds check comes before the full check
  function automatic iss_pkg::status_t store_insert(
    input int                                pos,
    input logic signed [iss_pkg::DATA_W-1:0] v
  );
    if (pos > held.size()) return iss_pkg::STS_OOB;
    if (held.size() >= iss_pkg::DEPTH) return iss_pkg::STS_FULL;
    held.insert(pos, v);
    return iss_pkg::STS_OK;
  endfunction

  function automatic iss_pkg::status_t store_remove(input int pos);
    if (held.size() == 0) return iss_pkg::STS_EMPTY;
    if (pos >= held.size()) return iss_pkg::STS_OOB;
    held.delete(pos);
    return iss_pkg::STS_OK;
  endfunction

  task automatic predict_request(input iss_pkg::req_t r);
    iss_pkg::status_t st;
    int               n;
    n = held.size();
    case (r.command)
      iss_pkg::CMD_INS_FRONT: st = store_insert(0, r.value);
      iss_pkg::CMD_INS_BACK:  st = store_insert(n, r.value);
      iss_pkg::CMD_INS_AT:    st = store_insert(int'(r.index), r.value);
      iss_pkg::CMD_DEL_FRONT: st = store_remove(0);
      iss_pkg::CMD_DEL_BACK:  st = store_remove(n - 1);
      iss_pkg::CMD_DEL_AT:    st = store_remove(int'(r.index));
      iss_pkg::CMD_READ_ALL: begin
        if (n == 0)
          owed_results.push_back(make_result(iss_pkg::STS_EMPTY, '0, 0, 1'b1));
        foreach (held[i])
          owed_results.push_back(make_result(iss_pkg::STS_OK, held[i], n, i == n - 1));
        return;
      end
      default: return;
    endcase
    owed_results.push_back(make_result(st, '0, held.size(), 1'b1));
  endtask

  function automatic iss_pkg::req_t random_request();
    iss_pkg::req_t r;
    int            n;
    int            roll;
    n = held.size();
    roll = $urandom_range(0, 99);
    // swing between filling and draining so both ends get hit
    if (n == iss_pkg::DEPTH) growing = 1'b0;
    else if (n == 0) growing = 1'b1;
    else if (roll < 4) growing = ~growing;
    roll = $urandom_range(0, 99);
    if (roll < 3)
      r.command = iss_pkg::CMD_UNUSED;
    else if (roll < 15)
      r.command = iss_pkg::CMD_READ_ALL;
    else if (roll < (growing ? 72 : 36))
      r.command = iss_pkg::cmd_t'($urandom_range(iss_pkg::CMD_INS_FRONT,
                                                 iss_pkg::CMD_INS_AT));
    else
      r.command = iss_pkg::cmd_t'($urandom_range(iss_pkg::CMD_DEL_FRONT,
                                                 iss_pkg::CMD_DEL_AT));
    case ($urandom_range(0, 9))
      0:       r.value = 32'sh8000_0000;
      1:       r.value = 32'sh7FFF_FFFF;
      2:       r.value = -32'sd1;
      default: r.value = $urandom;
    endcase
    if ($urandom_range(0, 99) < 80)
      r.index = iss_pkg::CNT_W'($urandom_range(0, n));
    else
      r.index = iss_pkg::CNT_W'($urandom_range(0, 31));
    return r;
  endfunction

  task automatic maybe_pause(input bit allowed);
    if (allowed && $urandom_range(0, 99) < 21) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // returns in the time step of the edge that took the request
  task automatic send_request(input iss_pkg::req_t r);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    iss_pkg::req_t r;
    int            issued;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        r.command = plan[i].command;
        r.value   = plan[i].value + k;
        r.index   = plan[i].index;
        maybe_pause(1'b1);
        send_request(r);
        predict_request(r);
        if (plan[i].typed)
          owed_results[$] = make_result(plan[i].status, '0, plan[i].count, 1'b1);
      end
    end

    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      r = random_request();
      maybe_pause(issued < 100 || issued > 200);
      send_request(r);
      predict_request(r);
      if (r.command != iss_pkg::CMD_UNUSED) issued++;
    end
    start <= 1'b0;

    while (owed_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin : result_check
    iss_pkg::rsp_t want;
    if (!rst && done) begin
      if (owed_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing owed: status %0d element %0d count %0d",
                                rsp.status, rsp.element, rsp.count));
      end else begin
        want = owed_results.pop_front();
        if (rsp.status !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
        if (rsp.element !== want.element)
          flag_mismatch($sformatf("element %0d, expected %0d", rsp.element, want.element));
        if (rsp.count !== want.count)
          flag_mismatch($sformatf("count %0d, expected %0d", rsp.count, want.count));
        if (rsp.last !== want.last)
          flag_mismatch($sformatf("last %0d, expected %0d", rsp.last, want.last));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
